FILE: rtl/psr_pkg.sv
package psr_pkg;

	localparam int SCREEN_WIDTH_MAX  = 1024;
	localparam int SCREEN_HEIGHT_MAX = 768;
	localparam int MAX_SPRITE        = 8;
	localparam int NEAR_CLIP         = 8;

	localparam int STORE_SIZE = SCREEN_WIDTH_MAX * SCREEN_HEIGHT_MAX;
	localparam int AW         = $clog2(STORE_SIZE);

	localparam logic [15:0] DEPTH_RESET = 16'h8000;
	localparam logic [15:0] DEPTH_MAX   = 16'h7FFF;

	// view space accumulators and projection numerators
	localparam int T_W = 40;
	localparam int N_W = 60;
	localparam logic signed [T_W-1:0] NEAR_LIM = T_W'(NEAR_CLIP) <<< 22;

	// shared divider
	localparam int DIV_W     = 62;
	localparam int QW        = 16;
	localparam int QCW       = $clog2(QW + 1);
	localparam int IZI_SHIFT = 37;

	// sprite edge counters
	localparam int SZW = 4;

	// multiply sequence: nine dot-product terms, four numerator partials
	localparam int MAC_STEPS = 13;
	localparam int MAC_CW    = 4;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UP         = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_RULE  = 4'd7;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_LATCH,
		DP_MAC,
		DP_NEAR,
		DP_DIVU,
		DP_DIVV,
		DP_DIVZ,
		DP_TAKE,
		DP_CLIP,
		DP_FIT,
		DP_READ,
		DP_EMIT,
		DP_FLUSH
	} dp_op_t;

	typedef enum logic [1:0] {
		SEL_U,
		SEL_V,
		SEL_Z
	} div_sel_t;

	typedef struct packed {
		logic clear_done;
		logic mac_last;
		logic near_fail;
		logic div_done;
		logic win_fail;
		logic fit_drop;
		logic pix_end;
		logic emit_block;
		logic pend_v;
	} dp_status_t;

endpackage

FILE: rtl/psr_div.sv
module psr_div import psr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic [QW-1:0]    quo,
	output logic             done
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsh_q;
	logic [QW-1:0]    quo_q;
	logic [QCW-1:0]   cnt_q;
	logic             busy_q;
	logic [DIV_W:0]   diff;

	assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
	assign quo  = quo_q;
	assign done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= QCW'(QW);
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den << (QW - 1);
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
			end
			quo_q <= {quo_q[QW-2:0], !diff[DIV_W]};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

FILE: rtl/psr_store.sv
module psr_store import psr_pkg::*; (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [STORE_SIZE];
	logic [15:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

FILE: rtl/psr_datapath.sv
module psr_datapath import psr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_op_t               op,
	output dp_status_t           st,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic signed [20:0]   pos_x,
	input  logic signed [20:0]   pos_y,
	input  logic signed [20:0]   pos_z,
	input  logic [7:0]           color,
	input  logic [9:0]           load_x,
	input  logic [9:0]           load_y,
	input  logic signed [15:0]   load_depth,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [9:0]           pixel_x,
	output logic [9:0]           pixel_y,
	output logic [7:0]           pixel_color,
	output logic signed [15:0]   pixel_depth,
	output logic                 last
);

	// configuration
	logic [62:0] origin_q;
	logic [47:0] right_q, up_q, fwd_q;
	logic [31:0] center_q;
	logic [47:0] clipw_q;
	logic [35:0] screen_q;
	logic [15:0] rule_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			right_q  <= '0;
			up_q     <= '0;
			fwd_q    <= '0;
			center_q <= '0;
			clipw_q  <= '0;
			screen_q <= '0;
			rule_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN:    origin_q <= cfg_data[62:0];
				CFG_RIGHT:     right_q  <= cfg_data[47:0];
				CFG_UP:        up_q     <= cfg_data[47:0];
				CFG_FORWARD:   fwd_q    <= cfg_data[47:0];
				CFG_CENTER:    center_q <= cfg_data[31:0];
				CFG_CLIP:      clipw_q  <= cfg_data[47:0];
				CFG_SCREEN:    screen_q <= cfg_data[35:0];
				CFG_SIZE_RULE: rule_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// particle
	logic signed [21:0] loc0_q, loc1_q, loc2_q;
	logic [7:0]         color_q;

	// multiply sequence
	logic [MAC_CW-1:0]     k_q;
	logic [MAC_CW-1:0]     ptag_q;
	logic                  pval_q;
	logic signed [22:0]    mul_a;
	logic signed [17:0]    mul_b;
	logic signed [40:0]    prod;
	logic signed [40:0]    prod_q;
	logic signed [T_W-1:0] tx_q, ty_q, tz_q;
	logic signed [N_W-1:0] nu_q, nv_q;
	logic [16:0]           xc8, yc8;

	assign xc8 = 17'(center_q[15:0]) + 17'd8;
	assign yc8 = 17'(center_q[31:16]) + 17'd8;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (k_q)
			4'd0:  begin mul_a = 23'(loc0_q); mul_b = 18'($signed(fwd_q[15:0]));    end
			4'd1:  begin mul_a = 23'(loc1_q); mul_b = 18'($signed(fwd_q[31:16]));   end
			4'd2:  begin mul_a = 23'(loc2_q); mul_b = 18'($signed(fwd_q[47:32]));   end
			4'd3:  begin mul_a = 23'(loc0_q); mul_b = 18'($signed(right_q[15:0]));  end
			4'd4:  begin mul_a = 23'(loc1_q); mul_b = 18'($signed(right_q[31:16])); end
			4'd5:  begin mul_a = 23'(loc2_q); mul_b = 18'($signed(right_q[47:32])); end
			4'd6:  begin mul_a = 23'(loc0_q); mul_b = 18'($signed(up_q[15:0]));     end
			4'd7:  begin mul_a = 23'(loc1_q); mul_b = 18'($signed(up_q[31:16]));    end
			4'd8:  begin mul_a = 23'(loc2_q); mul_b = 18'($signed(up_q[47:32]));    end
			4'd9:  begin mul_a = {4'b0, tz_q[18:0]};  mul_b = {1'b0, xc8}; end
			4'd10: begin mul_a = {4'b0, tz_q[37:19]}; mul_b = {1'b0, xc8}; end
			4'd11: begin mul_a = {4'b0, tz_q[18:0]};  mul_b = {1'b0, yc8}; end
			4'd12: begin mul_a = {4'b0, tz_q[37:19]}; mul_b = {1'b0, yc8}; end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			pval_q <= 1'b0;
		end else if (op == DP_LATCH) begin
			k_q    <= '0;
			pval_q <= 1'b0;
		end else if (op == DP_MAC) begin
			pval_q <= (k_q < MAC_CW'(MAC_STEPS));
			if (k_q < MAC_CW'(MAC_STEPS)) begin
				k_q <= k_q + 1'b1;
			end
		end else begin
			pval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == DP_LATCH) begin
			loc0_q  <= 22'(pos_x) - 22'($signed(origin_q[20:0]));
			loc1_q  <= 22'(pos_y) - 22'($signed(origin_q[41:21]));
			loc2_q  <= 22'(pos_z) - 22'($signed(origin_q[62:42]));
			color_q <= color;
			tx_q    <= '0;
			ty_q    <= '0;
			tz_q    <= '0;
			nu_q    <= '0;
			nv_q    <= '0;
		end else if (op == DP_NEAR) begin
			nu_q <= nu_q + (N_W'(tx_q) <<< 4);
			nv_q <= nv_q - (N_W'(ty_q) <<< 4);
		end else if (pval_q) begin
			case (ptag_q)
				4'd0, 4'd1, 4'd2: tz_q <= tz_q + T_W'(prod_q);
				4'd3, 4'd4, 4'd5: tx_q <= tx_q + T_W'(prod_q);
				4'd6, 4'd7, 4'd8: ty_q <= ty_q + T_W'(prod_q);
				4'd9:  nu_q <= nu_q + N_W'(prod_q);
				4'd10: nu_q <= nu_q + (N_W'(prod_q) <<< 19);
				4'd11: nv_q <= nv_q + N_W'(prod_q);
				4'd12: nv_q <= nv_q + (N_W'(prod_q) <<< 19);
				default: ;
			endcase
		end
		if (op == DP_MAC) begin
			prod_q <= prod;
			ptag_q <= k_q;
		end
	end

	// projection and reciprocal depth through the shared divider
	logic [N_W-1:0]   nu_abs, nv_abs;
	logic [DIV_W-1:0] div_num, div_den;
	logic             div_start, div_done;
	logic [QW-1:0]    div_quo;
	div_sel_t         div_sel_q;
	logic             neg_q;
	logic signed [16:0] u_q, v_q, quo_s;
	logic [15:0]      izi_q;

	assign nu_abs = nu_q[N_W-1] ? N_W'(-nu_q) : N_W'(nu_q);
	assign nv_abs = nv_q[N_W-1] ? N_W'(-nv_q) : N_W'(nv_q);
	assign div_start = (op == DP_DIVU) || (op == DP_DIVV) || (op == DP_DIVZ);

	always_comb begin
		div_num = DIV_W'(1) << IZI_SHIFT;
		div_den = DIV_W'(tz_q[38:0]);
		case (op)
			DP_DIVU: begin
				div_num = DIV_W'(nu_abs);
				div_den = DIV_W'(tz_q[38:0]) << 4;
			end
			DP_DIVV: begin
				div_num = DIV_W'(nv_abs);
				div_den = DIV_W'(tz_q[38:0]) << 4;
			end
			default: ;
		endcase
	end

	psr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	assign quo_s = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

	always_ff @(posedge clk) begin
		case (op)
			DP_DIVU: begin div_sel_q <= SEL_U; neg_q <= nu_q[N_W-1]; end
			DP_DIVV: begin div_sel_q <= SEL_V; neg_q <= nv_q[N_W-1]; end
			DP_DIVZ: begin div_sel_q <= SEL_Z; neg_q <= 1'b0; end
			DP_TAKE: begin
				case (div_sel_q)
					SEL_U:   u_q <= quo_s;
					SEL_V:   v_q <= quo_s;
					default: izi_q <= (div_quo > DEPTH_MAX) ? DEPTH_MAX : div_quo;
				endcase
			end
			default: ;
		endcase
	end

	// window test and sprite size
	logic             win_fail;
	logic [15:0]      izi_sh;
	logic [SZW-1:0]   pix, pix_q;

	assign win_fail = (v_q > $signed({5'b0, clipw_q[47:36]}))
		|| (u_q > $signed({5'b0, clipw_q[35:24]}))
		|| (v_q < $signed({5'b0, clipw_q[23:12]}))
		|| (u_q < $signed({5'b0, clipw_q[11:0]}));

	assign izi_sh = izi_q >> rule_q[7:4];

	always_comb begin
		if (rule_q[3:0] != '0) begin
			pix = rule_q[3:0];
		end else if (izi_sh < {12'b0, rule_q[11:8]}) begin
			pix = rule_q[11:8];
		end else if (izi_sh > {12'b0, rule_q[15:12]}) begin
			pix = rule_q[15:12];
		end else begin
			pix = izi_sh[3:0];
		end
		if (pix > SZW'(MAX_SPRITE)) begin
			pix = SZW'(MAX_SPRITE);
		end
	end

	// screen clip
	logic signed [17:0] us, vs, sb, sr, sw, ph, pw;
	logic               fit_drop;
	logic [SZW-1:0]     rows_q, cols_q, row_q, col_q;

	assign us = {u_q[16], u_q};
	assign vs = {v_q[16], v_q};
	assign sr = {6'b0, screen_q[11:0]};
	assign sb = {6'b0, screen_q[23:12]};
	assign sw = {6'b0, screen_q[35:24]};

	always_comb begin
		fit_drop = 1'b0;
		ph = {14'b0, pix_q};
		if (vs + ph > sb) begin
			ph = sb - vs;
			if (ph <= 0) begin
				fit_drop = 1'b1;
			end
		end
		pw = ph;
		if (us + pw > sr) begin
			pw = sr - us;
			if (pw <= 0) begin
				fit_drop = 1'b1;
			end
		end
		if (pw > sw - us) begin
			pw = sw - us;
		end
	end

	// pixel walk
	logic [12:0]   px, py;
	logic          inb;
	logic [AW-1:0] addr;
	logic [12:0]   px_s1, py_s1;
	logic          inb_s1;
	logic [AW-1:0] addr_s1;
	logic [15:0]   rdata;
	logic          pass;

	assign px   = u_q[12:0] + 13'(col_q);
	assign py   = v_q[12:0] + 13'(row_q);
	assign inb  = (32'(px) < SCREEN_WIDTH_MAX) && (32'(py) < SCREEN_HEIGHT_MAX);
	assign addr = AW'(32'(py) * SCREEN_WIDTH_MAX + 32'(px));
	assign pass = inb_s1 && ($signed(rdata) <= $signed(izi_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			cols_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			pix_q  <= '0;
		end else begin
			case (op)
				DP_CLIP: pix_q <= pix;
				DP_FIT: begin
					rows_q <= ph[SZW-1:0];
					cols_q <= (pw > 0) ? pw[SZW-1:0] : '0;
					row_q  <= '0;
					col_q  <= '0;
				end
				DP_EMIT: begin
					if (col_q == cols_q - 1'b1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == DP_READ) begin
			px_s1   <= px;
			py_s1   <= py;
			inb_s1  <= inb;
			addr_s1 <= addr;
		end
	end

	// depth store
	logic [AW-1:0] clr_q;
	logic          load_inb;
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [15:0]   st_wdata;

	assign load_inb = (32'(load_x) < SCREEN_WIDTH_MAX) && (32'(load_y) < SCREEN_HEIGHT_MAX);

	always_comb begin
		st_we    = 1'b0;
		st_waddr = addr_s1;
		st_wdata = izi_q;
		case (op)
			DP_CLEAR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				st_wdata = DEPTH_RESET;
			end
			DP_LOAD: begin
				st_we    = load_inb;
				st_waddr = AW'(32'(load_y) * SCREEN_WIDTH_MAX + 32'(load_x));
				st_wdata = load_depth;
			end
			DP_EMIT: st_we = pass;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (op == DP_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	psr_store u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   ((op == DP_READ) && inb),
		.raddr(addr),
		.rdata(rdata)
	);

	// one pending word holds back last until the next passing pixel or the end
	logic        pend_v_q, out_v_q, out_last_q;
	logic [9:0]  pend_x_q, pend_y_q, out_x_q, out_y_q;
	logic [7:0]  pend_c_q, out_c_q;
	logic [15:0] pend_d_q, out_d_q;
	logic        out_free, load_out, emit_new;

	assign out_free = !out_v_q || out_ready;
	assign emit_new = (op == DP_EMIT) && pass;
	assign load_out = pend_v_q && (emit_new || (op == DP_FLUSH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_new) begin
				pend_v_q <= 1'b1;
			end else if (op == DP_FLUSH) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_new) begin
			pend_x_q <= px_s1[9:0];
			pend_y_q <= py_s1[9:0];
			pend_c_q <= color_q;
			pend_d_q <= izi_q;
		end
		if (load_out) begin
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_c_q    <= pend_c_q;
			out_d_q    <= pend_d_q;
			out_last_q <= (op == DP_FLUSH);
		end
	end

	assign out_valid   = out_v_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_color = out_c_q;
	assign pixel_depth = out_d_q;
	assign last        = out_last_q;

	assign st.clear_done = (clr_q == AW'(STORE_SIZE - 1));
	assign st.mac_last   = (k_q == MAC_CW'(MAC_STEPS));
	assign st.near_fail  = (tz_q < NEAR_LIM);
	assign st.div_done   = div_done;
	assign st.win_fail   = win_fail;
	assign st.fit_drop   = fit_drop;
	assign st.pix_end    = (row_q == rows_q) || (cols_q == '0);
	assign st.emit_block = pend_v_q && !out_free;
	assign st.pend_v     = pend_v_q;

endmodule

FILE: rtl/psr_ctrl.sv
module psr_ctrl import psr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       opcode,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_op_t     op
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MAC,
		S_NEAR,
		S_DU,
		S_WU,
		S_DV,
		S_WV,
		S_DZ,
		S_WZ,
		S_CLIP,
		S_FIT,
		S_RD,
		S_CMP,
		S_FLUSH
	} state_t;

	state_t state_q, state_d;
	logic   out_free;

	// a flush may go when the output word frees up; blocked emit says it does not
	assign out_free = !st.emit_block;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = DP_NOP;
		case (state_q)
			S_CLEAR: begin
				op = DP_CLEAR;
				if (st.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_LOAD) begin
						op = DP_LOAD;
					end else begin
						op      = DP_LATCH;
						state_d = S_MAC;
					end
				end
			end
			S_MAC: begin
				op = DP_MAC;
				if (st.mac_last) begin
					state_d = S_NEAR;
				end
			end
			S_NEAR: begin
				op      = DP_NEAR;
				state_d = st.near_fail ? S_IDLE : S_DU;
			end
			S_DU: begin
				op      = DP_DIVU;
				state_d = S_WU;
			end
			S_WU: begin
				if (st.div_done) begin
					op      = DP_TAKE;
					state_d = S_DV;
				end
			end
			S_DV: begin
				op      = DP_DIVV;
				state_d = S_WV;
			end
			S_WV: begin
				if (st.div_done) begin
					op      = DP_TAKE;
					state_d = S_DZ;
				end
			end
			S_DZ: begin
				op      = DP_DIVZ;
				state_d = S_WZ;
			end
			S_WZ: begin
				if (st.div_done) begin
					op      = DP_TAKE;
					state_d = S_CLIP;
				end
			end
			S_CLIP: begin
				op      = DP_CLIP;
				state_d = st.win_fail ? S_IDLE : S_FIT;
			end
			S_FIT: begin
				op      = DP_FIT;
				state_d = st.fit_drop ? S_IDLE : S_RD;
			end
			S_RD: begin
				if (st.pix_end) begin
					state_d = S_FLUSH;
				end else begin
					op      = DP_READ;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (out_free) begin
					op      = DP_EMIT;
					state_d = S_RD;
				end
			end
			S_FLUSH: begin
				if (!st.pend_v) begin
					state_d = S_IDLE;
				end else if (!st.emit_block) begin
					op      = DP_FLUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/point_sprite_rasterizer_depth_test_top.sv
// Point sprite rasterizer with depth test. A draw word (opcode 0) carries a
// particle's world position and palette color; it is moved into view space
// against the camera registers, dropped if nearer than the near clip or outside
// the clip window, sized, clipped to the screen, and every covered pixel whose
// stored depth is not greater than the particle's reciprocal depth is written
// to the internal depth store and sent out as one word, the final one marked
// with last. A load word (opcode 1) writes one depth entry if its position
// lies on the screen and sends nothing. After reset the block sweeps the
// whole depth store to the most negative depth, one entry a cycle, and takes
// no input word until that is done; configuration writes are taken at any
// time but belong in idle gaps. A draw word computes the view transform and
// projection numerators on one shared 23x18 multiplier, then makes three
// 16-step passes of one shared restoring divider (horizontal and vertical
// projection, reciprocal depth), then for each pixel reads and
// test-and-writes the depth store. Stalls on the output channel hold the
// pixel walk; one finished word waits in the pending register while the
// next one is found.
module point_sprite_rasterizer_depth_test_top import psr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic signed [20:0]   pos_x,
	input  logic signed [20:0]   pos_y,
	input  logic signed [20:0]   pos_z,
	input  logic [7:0]           color,
	input  logic [9:0]           load_x,
	input  logic [9:0]           load_y,
	input  logic signed [15:0]   load_depth,
	// output words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [9:0]           pixel_x,
	output logic [9:0]           pixel_y,
	output logic [7:0]           pixel_color,
	output logic signed [15:0]   pixel_depth,
	output logic                 last,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	dp_op_t     op;
	dp_status_t st;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	psr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.in_ready(in_ready),
		.st      (st),
		.op      (op)
	);

	psr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.st         (st),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.color      (color),
		.load_x     (load_x),
		.load_y     (load_y),
		.load_depth (load_depth),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.pixel_depth(pixel_depth),
		.last       (last)
	);

endmodule
